### src/lpd_pkg.sv
package lpd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_first;
        logic       frame_last;
        logic       length_error;
    } result_t;

endpackage

### src/length_prefix_deframer.sv
// channel   direction  fields
// s_        in         s_stream_byte[7:0]
// m_        out        m_payload_byte[7:0], m_frame_first, m_frame_last, m_length_error
//
// one byte transfer per cycle while s_ready is high; a payload or error result is built from
// its byte and the per-byte counter and shift, then registered before it shows on m_
// header bytes give no result, but a negative length halts with an error on its last and every later byte
// a two-entry result buffer keeps s_ready high while one result waits on m_ready
// aresetn is synchronous, active low, and returns the block to the header phase
module length_prefix_deframer #(
    parameter int HEADER_BYTES = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_frame_first,
    output logic       m_frame_last,
    output logic       m_length_error
);

    logic             in_accept;
    logic             res_valid;
    lpd_pkg::result_t res;
    lpd_pkg::result_t m_data;

    assign in_accept = s_valid && s_ready;

    lpd_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_accept(in_accept),
        .in_byte  (s_stream_byte),
        .res_valid(res_valid),
        .res      (res)
    );

    lpd_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_valid),
        .push_data(res),
        .has_room (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign m_payload_byte = m_data.payload_byte;
    assign m_frame_first  = m_data.frame_first;
    assign m_frame_last   = m_data.frame_last;
    assign m_length_error = m_data.length_error;

endmodule

### src/lpd_parser.sv
module lpd_parser #(
    parameter int HEADER_BYTES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       in_byte,
    output logic             res_valid,
    output lpd_pkg::result_t res
);

    localparam int HW    = HEADER_BYTES * 8;
    localparam int RW    = HW - 1;
    localparam int CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    lpd_pkg::phase_t phase_reg, phase_next;
    logic [HW-1:0]    shift_reg, shift_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [RW-1:0]    remain_reg, remain_next;
    logic             first_reg, first_next;

    logic [HW+7:0] shift_wide;
    logic [HW-1:0] hdr_word;
    logic          hdr_done;
    logic          hdr_neg;
    logic          hdr_zero;
    logic          last;

    // header word as it stands once this byte is shifted in
    assign shift_wide = {shift_reg, in_byte};
    assign hdr_word   = shift_wide[HW-1:0];
    assign hdr_done   = (seen_reg == CNT_W'(HEADER_BYTES - 1));
    assign hdr_neg    = hdr_word[HW-1];
    assign hdr_zero   = (hdr_word == '0);
    assign last       = (remain_reg <= RW'(1));

    // next state
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            lpd_pkg::PH_HEADER: begin
                if (in_accept && hdr_done) begin
                    if (hdr_neg) begin
                        phase_next = lpd_pkg::PH_HALT;
                    end else if (hdr_zero) begin
                        phase_next = lpd_pkg::PH_HEADER;
                    end else begin
                        phase_next = lpd_pkg::PH_PAYLOAD;
                    end
                end
            end
            lpd_pkg::PH_PAYLOAD: begin
                if (in_accept && last) begin
                    phase_next = lpd_pkg::PH_HEADER;
                end
            end
            lpd_pkg::PH_HALT: begin
                phase_next = lpd_pkg::PH_HALT;
            end
            default: begin
                phase_next = lpd_pkg::PH_HALT;
            end
        endcase
    end

    // counters and header gather
    always_comb begin
        shift_next  = shift_reg;
        seen_next   = seen_reg;
        remain_next = remain_reg;
        first_next  = first_reg;
        if (in_accept && phase_reg == lpd_pkg::PH_HEADER) begin
            shift_next = hdr_word;
            if (hdr_done) begin
                seen_next   = '0;
                remain_next = hdr_word[RW-1:0];
                first_next  = 1'b1;
            end else begin
                seen_next = seen_reg + CNT_W'(1);
            end
        end else if (in_accept && phase_reg == lpd_pkg::PH_PAYLOAD) begin
            first_next  = 1'b0;
            remain_next = remain_reg - RW'(1);
        end
    end

    // outputs
    always_comb begin
        res_valid        = 1'b0;
        res.payload_byte = 8'd0;
        res.frame_first  = 1'b0;
        res.frame_last   = 1'b0;
        res.length_error = 1'b0;
        case (phase_reg)
            lpd_pkg::PH_HEADER: begin
                if (hdr_done && hdr_neg) begin
                    res_valid        = in_accept;
                    res.length_error = 1'b1;
                end
            end
            lpd_pkg::PH_PAYLOAD: begin
                res_valid        = in_accept;
                res.payload_byte = in_byte;
                res.frame_first  = first_reg;
                res.frame_last   = last;
            end
            default: begin
                res_valid        = in_accept;
                res.length_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lpd_pkg::PH_HEADER;
            seen_reg  <= '0;
            first_reg <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        remain_reg <= remain_next;
    end

endmodule

### src/lpd_out_buf.sv
module lpd_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lpd_pkg::result_t push_data,
    output logic             has_room,
    output logic             m_valid,
    input  logic             m_ready,
    output lpd_pkg::result_t m_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    lpd_pkg::result_t out_reg, out_next;
    lpd_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop      = out_valid_reg && m_ready;
    assign has_room = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            // result register busy: park the new result in the skid slot
            if (out_valid_reg) begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

### src/lpd_checker.sv
module lpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_payload_byte,
    input logic       m_frame_first,
    input logic       m_frame_last,
    input logic       m_length_error
);

    logic err_seen_reg;
    logic expect_first_reg;
    logic out_xfer;

    assign out_xfer = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg     <= 1'b0;
            expect_first_reg <= 1'b1;
        end else if (out_xfer) begin
            if (m_length_error) begin
                err_seen_reg <= 1'b1;
            end else begin
                expect_first_reg <= m_frame_last;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte)
            && $stable(m_frame_first) && $stable(m_frame_last) && $stable(m_length_error))
        else $error("result changed while stalled");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_length_error |->
            m_payload_byte == 8'd0 && !m_frame_first && !m_frame_last)
        else $error("error result carries payload marks");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && err_seen_reg |-> m_length_error)
        else $error("payload result after length error");

    a_first_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_length_error |-> m_frame_first == expect_first_reg)
        else $error("frame first mark out of sequence");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_payload_byte(m_payload_byte),
    .m_frame_first (m_frame_first),
    .m_frame_last  (m_frame_last),
    .m_length_error(m_length_error)
);

### bench/length_prefix_deframer_checker.sv
`timescale 1ns / 1ps

module length_prefix_deframer_checker #(
    parameter int HDR_BYTES = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_payload_byte,
    input  logic       m_frame_first,
    input  logic       m_frame_last,
    input  logic       m_length_error,
    output int         fail_count,
    output int         pending
);

    localparam int HDR_BITS = HDR_BYTES * 8;
    localparam logic [63:0] HDR_MASK =
        (HDR_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << HDR_BITS) - 64'd1);

    lpd_pkg::phase_t  phase;
    logic [63:0]      hdr_shift;
    logic [3:0]       hdr_seen;
    logic [62:0]      bytes_left;
    logic             first_due;
    lpd_pkg::result_t out_due[$];
    lpd_pkg::result_t want;

    task automatic restart_header();
        phase      = lpd_pkg::PH_HEADER;
        hdr_shift  = '0;
        hdr_seen   = '0;
        bytes_left = '0;
        first_due  = 1'b1;
    endtask

    task automatic push_error();
        lpd_pkg::result_t r;
        r.payload_byte = 8'h00;
        r.frame_first  = 1'b0;
        r.frame_last   = 1'b0;
        r.length_error = 1'b1;
        out_due.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        lpd_pkg::result_t r;
        logic             last;
        case (phase)
            lpd_pkg::PH_HEADER: begin
                hdr_shift = {hdr_shift[55:0], b} & HDR_MASK;
                hdr_seen  = hdr_seen + 4'd1;
                if (hdr_seen >= HDR_BYTES) begin
                    if (hdr_shift[HDR_BITS-1]) begin
                        // negative length: sticky halt
                        phase    = lpd_pkg::PH_HALT;
                        hdr_seen = '0;
                        push_error();
                    end else if (hdr_shift == '0) begin
                        restart_header();
                    end else begin
                        bytes_left = hdr_shift[62:0];
                        phase      = lpd_pkg::PH_PAYLOAD;
                        hdr_shift  = '0;
                        hdr_seen   = '0;
                        first_due  = 1'b1;
                    end
                end
            end
            lpd_pkg::PH_PAYLOAD: begin
                last           = (bytes_left <= 63'd1);
                r.payload_byte = b;
                r.frame_first  = first_due;
                r.frame_last   = last;
                r.length_error = 1'b0;
                out_due.push_back(r);
                first_due = 1'b0;
                if (last) begin
                    restart_header();
                end else begin
                    bytes_left = bytes_left - 63'd1;
                end
            end
            default: begin
                push_error();
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns mismatch %s: expected %02h actual %02h", $time, name, want_v,
                     got_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_header();
            out_due.delete();
            fail_count = 0;
        end else begin
            // push before pop: a same-edge transfer on m_ belongs to an older byte anyway
            if (s_valid && s_ready) begin
                deframe_byte(s_stream_byte);
            end
            if (m_valid && m_ready) begin
                if (out_due.size() == 0) begin
                    $display("%0t ns unexpected result: expected none actual %02h %b%b%b",
                             $time, m_payload_byte, m_frame_first, m_frame_last,
                             m_length_error);
                    fail_count++;
                end else begin
                    want = out_due.pop_front();
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("frame_first", {7'd0, want.frame_first}, {7'd0, m_frame_first});
                    check_field("frame_last", {7'd0, want.frame_last}, {7'd0, m_frame_last});
                    check_field("length_error", {7'd0, want.length_error},
                                {7'd0, m_length_error});
                end
            end
        end
        pending = out_due.size();
    end

endmodule

### bench/tb_length_prefix_deframer.sv
`timescale 1ns / 1ps

module tb_length_prefix_deframer;

    localparam int HDR_BYTES   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 450;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic [7:0] s_stream_byte = 8'h00;
    logic       m_ready       = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_payload_byte;
    logic       m_frame_first;
    logic       m_frame_last;
    logic       m_length_error;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_go        = 1'b0;
    bit hold_used      = 1'b0;

    length_prefix_deframer #(
        .HEADER_BYTES(HDR_BYTES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_stream_byte(s_stream_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload_byte(m_payload_byte),
        .m_frame_first(m_frame_first),
        .m_frame_last(m_frame_last),
        .m_length_error(m_length_error)
    );

    length_prefix_deframer_checker #(
        .HDR_BYTES(HDR_BYTES)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_stream_byte(s_stream_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload_byte(m_payload_byte),
        .m_frame_first(m_frame_first),
        .m_frame_last(m_frame_last),
        .m_length_error(m_length_error),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up into s_ready
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [63:0] len);
        for (int i = HDR_BYTES - 1; i >= 0; i--) begin
            send_byte(len[i*8 +: 8]);
        end
    endtask

    task automatic send_frame(input int len);
        send_header(64'(len));
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(300, 100);
        end
        return $urandom_range(24, 1);
    endfunction

    initial begin
        logic [63:0] neg_len;
        int          target;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-byte frame, empty frame, then a short frame with the payload extremes
        send_header(64'd1);
        send_byte(8'hFF);
        send_header(64'd0);
        send_header(64'd2);
        send_byte(8'h00);
        send_byte(8'hFF);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_go       <= 1'b1;
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default: begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                send_frame(pick_len());
            end
        end

        // negative length halts the block; later bytes each return the error again
        neg_len     = {32'($urandom), 32'($urandom)};
        neg_len[63] = 1'b1;
        send_header(neg_len);
        for (int i = 0; i < 4; i++) begin
            send_byte(8'($urandom_range(255)));
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
